// ===== rtl/warp_loop_tracking_table_core_macros.svh =====
// Assertion macros for the loop tracking table
`ifndef WARP_LOOP_TRACKING_TABLE_CORE_MACROS_SVH
`define WARP_LOOP_TRACKING_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define WLTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WLTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WLTT_ASSERT_IMP(lbl, ante, cons, msg)
`define WLTT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/wltt_pkg.sv =====
`default_nettype none
package wltt_pkg;

    localparam int PC_W    = 32;
    localparam int STAMP_W = 32;
    localparam int MASK_W  = 32;

    typedef enum logic [2:0] {
        KIND_PUSH    = 3'd0,
        KIND_SEARCH  = 3'd1,
        KIND_SETBR   = 3'd2,
        KIND_POP     = 3'd3,
        KIND_ENDLOOP = 3'd4,
        KIND_UPDATE  = 3'd5,
        KIND_BIGGEST = 3'd6,
        KIND_UNUSED  = 3'd7
    } kind_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_ADDR = 2'd2;

    typedef struct packed {
        logic push;
        logic rd;
        logic upd;
    } lane_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/warp_loop_tracking_table_core.sv =====
`default_nettype none
// Channel | Handshake           | Payload
// in      | in_valid / in_ready | kind warp target_pc branch_pc current_pc entry_index
//         |                     | lane_mask cycle_stamp
// out     | out_valid/out_ready | found hit_index max_period status
// One item at a time. push, set branch, pop: map read and act; update cycle: plus lane update;
// search: compare per entry walked; end loop: every entry, then map write-back (not if empty);
// biggest period: one warp head per cycle through the map memory.
// Reset clears the per-warp valid bits; a never-written warp reads as an empty stack.
// in_ready is high only when the control is idle; a held result does not block a new transfer.
`include "warp_loop_tracking_table_core_macros.svh"
module warp_loop_tracking_table_core #(
    parameter int WARP_COUNT  = 48,
    parameter int STACK_DEPTH = 8,
    parameter int LANE_COUNT  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [5:0]  warp,
    input  wire logic [31:0] target_pc,
    input  wire logic [31:0] branch_pc,
    input  wire logic [31:0] current_pc,
    input  wire logic [2:0]  entry_index,
    input  wire logic [31:0] lane_mask,
    input  wire logic [31:0] cycle_stamp,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [2:0]       hit_index,
    output logic [31:0]      max_period,
    output logic [1:0]       status
);

    localparam int SW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int WAW   = (WARP_COUNT > 1) ? $clog2(WARP_COUNT) : 1;
    localparam int SCW   = $clog2(WARP_COUNT + 1);
    localparam int EDEP  = WARP_COUNT * STACK_DEPTH;
    localparam int MW    = (EDEP > 1) ? $clog2(EDEP) : 1;

    typedef logic [STACK_DEPTH-1:0][SW-1:0] map_t;
    typedef struct packed {
        logic [CW-1:0] cnt;
        map_t          slots;
    } mapword_t;

    typedef enum logic [2:0] {
        S_IDLE, S_MAP, S_WALK, S_CMP, S_WB, S_UPD, S_SCAN, S_DONE
    } state_t;

    function automatic logic [MW-1:0] mk_addr(input logic [WAW-1:0] w, input logic [SW-1:0] s);
        mk_addr = MW'(w * STACK_DEPTH + s);
    endfunction

    state_t                 state_reg, state_next;
    wltt_pkg::kind_t        kind_reg, kind_next;
    logic [5:0]             warp_reg, warp_next;
    logic [31:0]            tpc_reg, tpc_next, bpc_reg, bpc_next, cpc_reg, cpc_next;
    logic [2:0]             idx_reg, idx_next;
    logic [31:0]            mask_reg, mask_next, stamp_reg, stamp_next;
    logic [CW-1:0]          i_reg, i_next, j_reg, j_next, r_reg, r_next;
    map_t                   nmap_reg, nmap_next;
    logic [SCW-1:0]         scan_reg, scan_next;
    logic                   s1_v_reg, s1_v_next, s2_v_reg, s2_v_next, s2_ne_reg, s2_ne_next;
    logic [WAW-1:0]         s1_w_reg, s1_w_next;
    logic                   rfound_reg, rfound_next;
    logic [2:0]             rhit_reg, rhit_next;
    logic [1:0]             rstat_reg, rstat_next;
    logic                   ov_reg, ov_next, of_reg, of_next;
    logic [2:0]             oh_reg, oh_next;
    logic [31:0]            om_reg, om_next;
    logic [1:0]             os_reg, os_next;

    mapword_t               map_mem [WARP_COUNT];
    logic [WARP_COUNT-1:0]  map_vld_reg;
    mapword_t               map_q;
    logic                   map_vld_q;
    logic                   map_rd_en, map_we;
    logic [WAW-1:0]         map_rd_addr;
    mapword_t               map_wd;

    logic [31:0]            tgt_mem [EDEP];
    logic [31:0]            br_mem  [EDEP];
    logic [31:0]            tq, bq;
    logic                   tgt_we, br_we, ent_rd;

    map_t                   ident, eff_map;
    logic [CW-1:0]          eff_cnt;
    logic [SW-1:0]          idx_s, ent_slot;
    logic [WAW-1:0]         wi;
    logic [MW-1:0]          ent_addr, lane_addr;
    logic                   warp_ok, keep, issue, merge_clear;
    wltt_pkg::lane_cmd_t    lane_cmd;
    logic [31:0]            lane0_per, merge_max;
    logic [31:0]            lane_per [LANE_COUNT];

    always_comb
    begin
        for (int k = 0; k < STACK_DEPTH; k++)
        begin
            ident[k] = SW'(k);
        end
    end

    assign eff_cnt  = map_vld_q ? map_q.cnt : '0;
    assign eff_map  = map_vld_q ? map_q.slots : ident;
    assign idx_s    = SW'(idx_reg);
    assign wi       = WAW'(warp_reg);
    assign warp_ok  = (warp_reg < WARP_COUNT);
    assign ent_slot = (state_reg == S_WALK) ? eff_map[i_reg[SW-1:0]] :
                      (kind_reg == wltt_pkg::KIND_PUSH) ? eff_map[SW'(eff_cnt)] : eff_map[idx_s];
    assign ent_addr  = mk_addr(wi, ent_slot);
    assign lane_addr = (state_reg == S_SCAN) ? mk_addr(s1_w_reg, eff_map[0]) : ent_addr;
    assign keep      = !((cpc_reg < tq) || (cpc_reg > bq));
    assign issue     = (scan_reg < WARP_COUNT);

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        warp_next   = warp_reg;
        tpc_next    = tpc_reg;
        bpc_next    = bpc_reg;
        cpc_next    = cpc_reg;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        stamp_next  = stamp_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        r_next      = r_reg;
        nmap_next   = nmap_reg;
        scan_next   = scan_reg;
        s1_v_next   = 1'b0;
        s1_w_next   = s1_w_reg;
        s2_v_next   = 1'b0;
        s2_ne_next  = s2_ne_reg;
        rfound_next = rfound_reg;
        rhit_next   = rhit_reg;
        rstat_next  = rstat_reg;
        ov_next     = ov_reg && !out_ready;
        of_next     = of_reg;
        oh_next     = oh_reg;
        om_next     = om_reg;
        os_next     = os_reg;
        map_rd_en   = 1'b0;
        map_rd_addr = WAW'(warp);
        map_we      = 1'b0;
        map_wd      = '{cnt: eff_cnt, slots: eff_map};
        tgt_we      = 1'b0;
        br_we       = 1'b0;
        ent_rd      = 1'b0;
        lane_cmd    = '0;
        merge_clear = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = wltt_pkg::kind_t'(kind);
                    warp_next   = warp;
                    tpc_next    = target_pc;
                    bpc_next    = branch_pc;
                    cpc_next    = current_pc;
                    idx_next    = entry_index;
                    mask_next   = lane_mask;
                    stamp_next  = cycle_stamp;
                    rfound_next = 1'b0;
                    rhit_next   = '0;
                    rstat_next  = wltt_pkg::STATUS_OK;
                    map_rd_en   = 1'b1;
                    merge_clear = 1'b1;
                    scan_next   = '0;
                    if (kind == wltt_pkg::KIND_BIGGEST)
                        state_next = S_SCAN;
                    else if (kind == wltt_pkg::KIND_UNUSED)
                        state_next = S_DONE;
                    else
                        state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_DONE;
                if (!warp_ok)
                begin
                    rstat_next = wltt_pkg::STATUS_ADDR;
                end
                else
                begin
                    case (kind_reg)
                        wltt_pkg::KIND_PUSH:
                        begin
                            if (eff_cnt == STACK_DEPTH)
                            begin
                                rstat_next = wltt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                tgt_we        = 1'b1;
                                br_we         = 1'b1;
                                lane_cmd.push = 1'b1;
                                map_we        = 1'b1;
                                map_wd.cnt    = CW'(eff_cnt + 1'b1);
                            end
                        end
                        wltt_pkg::KIND_SEARCH, wltt_pkg::KIND_ENDLOOP:
                        begin
                            if (eff_cnt != '0)
                            begin
                                i_next     = '0;
                                j_next     = '0;
                                r_next     = CW'(eff_cnt - 1'b1);
                                nmap_next  = eff_map;
                                state_next = S_WALK;
                            end
                        end
                        wltt_pkg::KIND_SETBR:
                        begin
                            if (idx_reg >= eff_cnt)
                                rstat_next = wltt_pkg::STATUS_ADDR;
                            else
                                br_we = 1'b1;
                        end
                        wltt_pkg::KIND_POP:
                        begin
                            if (idx_reg > eff_cnt)
                            begin
                                rstat_next = wltt_pkg::STATUS_ADDR;
                            end
                            else
                            begin
                                map_we     = 1'b1;
                                map_wd.cnt = CW'(idx_reg);
                            end
                        end
                        wltt_pkg::KIND_UPDATE:
                        begin
                            if (idx_reg >= eff_cnt)
                            begin
                                rstat_next = wltt_pkg::STATUS_ADDR;
                            end
                            else
                            begin
                                lane_cmd.rd = 1'b1;
                                state_next  = S_UPD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                ent_rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (kind_reg == wltt_pkg::KIND_SEARCH)
                begin
                    if (tq == tpc_reg)
                    begin
                        rfound_next = 1'b1;
                        rhit_next   = 3'(i_reg);
                        state_next  = S_DONE;
                    end
                    else if (CW'(i_reg + 1'b1) == eff_cnt)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = CW'(i_reg + 1'b1);
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    if (keep)
                    begin
                        nmap_next[j_reg[SW-1:0]] = eff_map[i_reg[SW-1:0]];
                        j_next = CW'(j_reg + 1'b1);
                    end
                    else
                    begin
                        nmap_next[r_reg[SW-1:0]] = eff_map[i_reg[SW-1:0]];
                        r_next = CW'(r_reg - 1'b1);
                    end
                    if (CW'(i_reg + 1'b1) == eff_cnt)
                    begin
                        state_next = S_WB;
                    end
                    else
                    begin
                        i_next     = CW'(i_reg + 1'b1);
                        state_next = S_WALK;
                    end
                end
            end
            S_WB:
            begin
                map_we     = 1'b1;
                map_wd     = '{cnt: j_reg, slots: nmap_reg};
                state_next = S_DONE;
            end
            S_UPD:
            begin
                lane_cmd.upd = 1'b1;
                state_next   = S_DONE;
            end
            S_SCAN:
            begin
                map_rd_en   = issue;
                map_rd_addr = WAW'(scan_reg);
                scan_next   = SCW'(scan_reg + issue);
                s1_v_next   = issue;
                s1_w_next   = WAW'(scan_reg);
                lane_cmd.rd = s1_v_reg;
                s2_v_next   = s1_v_reg;
                s2_ne_next  = (eff_cnt != '0);
                if (!issue && !s1_v_reg && !s2_v_reg)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    of_next    = rfound_reg;
                    oh_next    = rhit_reg;
                    om_next    = (kind_reg == wltt_pkg::KIND_BIGGEST) ? merge_max : '0;
                    os_next    = rstat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            kind_reg   <= wltt_pkg::KIND_UNUSED;
            scan_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_v_reg   <= s1_v_next;
            s2_v_reg   <= s2_v_next;
            ov_reg     <= ov_next;
            kind_reg   <= kind_next;
            scan_reg   <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        warp_reg   <= warp_next;
        tpc_reg    <= tpc_next;
        bpc_reg    <= bpc_next;
        cpc_reg    <= cpc_next;
        idx_reg    <= idx_next;
        mask_reg   <= mask_next;
        stamp_reg  <= stamp_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        r_reg      <= r_next;
        nmap_reg   <= nmap_next;
        s1_w_reg   <= s1_w_next;
        s2_ne_reg  <= s2_ne_next;
        rfound_reg <= rfound_next;
        rhit_reg   <= rhit_next;
        rstat_reg  <= rstat_next;
        of_reg     <= of_next;
        oh_reg     <= oh_next;
        om_reg     <= om_next;
        os_reg     <= os_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            map_vld_reg <= '0;
        else if (map_we)
            map_vld_reg[wi] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[wi] <= map_wd;
        if (map_rd_en)
        begin
            map_q     <= map_mem[map_rd_addr];
            map_vld_q <= map_vld_reg[map_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[ent_addr] <= tpc_reg;
        if (br_we)
            br_mem[ent_addr] <= bpc_reg;
        if (ent_rd)
        begin
            tq <= tgt_mem[ent_addr];
            bq <= br_mem[ent_addr];
        end
    end

    for (genvar g = 0; g < LANE_COUNT; g++)
    begin : g_lane
        logic sel;
        if (g < wltt_pkg::MASK_W)
        begin : g_sel
            assign sel = mask_reg[g];
        end
        else
        begin : g_nosel
            assign sel = 1'b0;
        end
        wltt_lane #(.DEPTH(EDEP), .ADDR_W(MW)) u_lane (
            .clk(clk), .cmd(lane_cmd), .addr(lane_addr), .sel(sel),
            .stamp(stamp_reg), .period(lane_per[g])
        );
    end

    assign lane0_per = lane_per[0];

    wltt_merge u_merge (
        .clk(clk), .rst_n(rst_n), .clear(merge_clear), .en(s2_v_reg),
        .nonempty(s2_ne_reg), .period(lane0_per), .max_period(merge_max)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ov_reg;
    assign found      = of_reg;
    assign hit_index  = oh_reg;
    assign max_period = om_reg;
    assign status     = os_reg;

    `WLTT_ASSERT_NXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "ready after transfer")
    `WLTT_ASSERT_IMP(a_found_ok, out_valid && found, status == wltt_pkg::STATUS_OK, "hit with error")
    `WLTT_ASSERT_IMP(a_map_cnt, map_we, map_wd.cnt <= STACK_DEPTH, "stack count overflow")
    `WLTT_ASSERT_IMP(a_lane_cmd, lane_cmd.push, !lane_cmd.upd && !lane_cmd.rd, "lane cmd clash")

endmodule
`default_nettype wire

// ===== rtl/wltt_lane.sv =====
`default_nettype none
module wltt_lane #(
    parameter int DEPTH  = 384,
    parameter int ADDR_W = 9
) (
    input  wire logic                           clk,
    input  wire wltt_pkg::lane_cmd_t            cmd,
    input  wire logic [ADDR_W-1:0]              addr,
    input  wire logic                           sel,
    input  wire logic [wltt_pkg::STAMP_W-1:0]   stamp,
    output logic      [wltt_pkg::STAMP_W-1:0]   period
);

    logic [wltt_pkg::STAMP_W-1:0] last_mem [DEPTH];
    logic [wltt_pkg::STAMP_W-1:0] per_mem  [DEPTH];
    logic [wltt_pkg::STAMP_W-1:0] last_q;
    logic [wltt_pkg::STAMP_W-1:0] per_q;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            last_mem[addr] <= stamp;
            per_mem[addr]  <= '0;
        end
        else if (cmd.upd && sel)
        begin
            last_mem[addr] <= stamp;
            per_mem[addr]  <= stamp - last_q;
        end
        if (cmd.rd)
        begin
            last_q <= last_mem[addr];
            per_q  <= per_mem[addr];
        end
    end

    assign period = per_q;

endmodule
`default_nettype wire

// ===== rtl/wltt_merge.sv =====
`default_nettype none
module wltt_merge (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           clear,
    input  wire logic                           en,
    input  wire logic                           nonempty,
    input  wire logic [wltt_pkg::STAMP_W-1:0]   period,
    output logic      [wltt_pkg::STAMP_W-1:0]   max_period
);

    logic [wltt_pkg::STAMP_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (clear)
        begin
            acc_reg <= '0;
        end
        else if (en && nonempty && (period > acc_reg))
        begin
            acc_reg <= period;
        end
    end

    assign max_period = acc_reg;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int NWARP = 48;
    localparam int DEPTH = 8;
    localparam int LANES = 32;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        found;
        logic [2:0]  hit_index;
        logic [31:0] max_period;
        logic [1:0]  status;
    } loop_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  kind;
    logic [5:0]  warp;
    logic [31:0] target_pc;
    logic [31:0] branch_pc;
    logic [31:0] current_pc;
    logic [2:0]  entry_index;
    logic [31:0] lane_mask;
    logic [31:0] cycle_stamp;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [2:0]  hit_index;
    logic [31:0] max_period;
    logic [1:0]  status;

    warp_loop_tracking_table_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .warp(warp), .target_pc(target_pc), .branch_pc(branch_pc),
        .current_pc(current_pc), .entry_index(entry_index), .lane_mask(lane_mask),
        .cycle_stamp(cycle_stamp),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .hit_index(hit_index), .max_period(max_period), .status(status)
    );

    // shadow table
    int unsigned depth_of [NWARP];
    logic [31:0] tgt_of [NWARP][DEPTH];
    logic [31:0] br_of [NWARP][DEPTH];
    logic [31:0] last_of [NWARP][DEPTH][LANES];
    logic [31:0] per_of [NWARP][DEPTH][LANES];

    loop_result_t expected_results[$];
    int  error_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    longint cycles;

    // recently pushed targets, shared by all warps, to steer searches and loop exits
    logic [31:0] pc_pool[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic loop_result_t predict_loop_op(
        input logic [2:0] k, input logic [5:0] w, input logic [31:0] tpc,
        input logic [31:0] bpc, input logic [31:0] cpc, input logic [2:0] idx,
        input logic [31:0] mask, input logic [31:0] stamp);
        loop_result_t r;
        int unsigned n;
        int unsigned j;
        logic [31:0] best;
        r = '0;
        if (k <= wltt_pkg::KIND_UPDATE && w >= NWARP)
        begin
            r.status = wltt_pkg::STATUS_ADDR;
            return r;
        end
        case (wltt_pkg::kind_t'(k))
            wltt_pkg::KIND_PUSH:
            begin
                n = depth_of[w];
                if (n >= DEPTH)
                    r.status = wltt_pkg::STATUS_FULL;
                else
                begin
                    tgt_of[w][n] = tpc;
                    br_of[w][n] = bpc;
                    for (int i = 0; i < LANES; i++)
                    begin
                        last_of[w][n][i] = stamp;
                        per_of[w][n][i] = '0;
                    end
                    depth_of[w] = n + 1;
                end
            end
            wltt_pkg::KIND_SEARCH:
                for (int i = 0; i < depth_of[w]; i++)
                    if (tgt_of[w][i] == tpc)
                    begin
                        r.found = 1'b1;
                        r.hit_index = i[2:0];
                        break;
                    end
            wltt_pkg::KIND_SETBR:
                if (idx >= depth_of[w])
                    r.status = wltt_pkg::STATUS_ADDR;
                else
                    br_of[w][idx] = bpc;
            wltt_pkg::KIND_POP:
                if (idx > depth_of[w])
                    r.status = wltt_pkg::STATUS_ADDR;
                else
                    depth_of[w] = 32'(idx);
            wltt_pkg::KIND_ENDLOOP:
            begin
                j = 0;
                for (int i = 0; i < depth_of[w]; i++)
                begin
                    if (cpc < tgt_of[w][i] || cpc > br_of[w][i])
                        continue;
                    tgt_of[w][j] = tgt_of[w][i];
                    br_of[w][j] = br_of[w][i];
                    last_of[w][j] = last_of[w][i];
                    per_of[w][j] = per_of[w][i];
                    j++;
                end
                depth_of[w] = j;
            end
            wltt_pkg::KIND_UPDATE:
                if (idx >= depth_of[w])
                    r.status = wltt_pkg::STATUS_ADDR;
                else
                    for (int i = 0; i < LANES; i++)
                        if (mask[i])
                        begin
                            per_of[w][idx][i] = stamp - last_of[w][idx][i];
                            last_of[w][idx][i] = stamp;
                        end
            wltt_pkg::KIND_BIGGEST:
            begin
                best = '0;
                for (int i = 0; i < NWARP; i++)
                    if (depth_of[i] != 0 && per_of[i][0][0] > best)
                        best = per_of[i][0][0];
                r.max_period = best;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_op(input wltt_pkg::kind_t k, input logic [5:0] w,
                           input logic [31:0] tpc, input logic [31:0] bpc,
                           input logic [31:0] cpc, input logic [2:0] idx,
                           input logic [31:0] mask, input logic [31:0] stamp);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        warp <= w;
        target_pc <= tpc;
        branch_pc <= bpc;
        current_pc <= cpc;
        entry_index <= idx;
        lane_mask <= mask;
        cycle_stamp <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results = {expected_results,
                            predict_loop_op(k, w, tpc, bpc, cpc, idx, mask, stamp)};
    endtask

    // receiver
    always @(posedge clk)
    begin
        loop_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", '0, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (found !== want.found)
                        report_mismatch("found", 32'(found), 32'(want.found));
                    if (hit_index !== want.hit_index)
                        report_mismatch("hit_index", 32'(hit_index), 32'(want.hit_index));
                    if (max_period !== want.max_period)
                        report_mismatch("max_period", max_period, want.max_period);
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed;
        send_op(wltt_pkg::KIND_BIGGEST, 6'd0, '0, '0, '0, '0, '0, '0);
        send_op(wltt_pkg::KIND_SEARCH, 6'd3, 32'h100, '0, '0, '0, '0, '0);
        send_op(wltt_pkg::KIND_PUSH, 6'd0, 32'h100, 32'h200, '0, '0, 32'hFFFF_FFFF,
                32'hFFFF_FFF0);
        send_op(wltt_pkg::KIND_UPDATE, 6'd0, '0, '0, '0, 3'd0, 32'h0000_0001, 32'h0000_0010);
        send_op(wltt_pkg::KIND_BIGGEST, 6'd63, '0, '0, '0, '0, '0, '0);
        for (int i = 0; i < 9; i++)
            send_op(wltt_pkg::KIND_PUSH, 6'd47, 32'(32'h10 * i), 32'(32'hFFFF_FFFF - i), '0,
                    '0, 32'hAAAA_5555, 32'd0);
        send_op(wltt_pkg::KIND_SEARCH, 6'd47, 32'h30, '0, '0, '0, '0, '0);
        send_op(wltt_pkg::KIND_SETBR, 6'd47, '0, 32'h25, '0, 3'd7, '0, '0);
        send_op(wltt_pkg::KIND_ENDLOOP, 6'd47, '0, '0, 32'h28, '0, '0, '0);
        send_op(wltt_pkg::KIND_POP, 6'd47, '0, '0, '0, 3'd7, '0, '0);
        send_op(wltt_pkg::KIND_POP, 6'd47, '0, '0, '0, 3'd0, '0, '0);
        send_op(wltt_pkg::KIND_SETBR, 6'd47, '0, '0, '0, 3'd0, '0, '0);
        send_op(wltt_pkg::KIND_UPDATE, 6'd47, '0, '0, '0, 3'd0, 32'hFFFF_FFFF, 32'd5);
        send_op(wltt_pkg::KIND_PUSH, 6'd48, '0, '0, '0, '0, '0, '0);
        send_op(wltt_pkg::KIND_POP, 6'd63, '0, '0, '0, '0, '0, '0);
        send_op(wltt_pkg::KIND_UNUSED, 6'd5, 32'hFFFF_FFFF, '0, '0, 3'd7, '0, '0);
        drain();
    endtask

    task automatic random_op;
        logic [5:0] w;
        logic [31:0] pc;
        int sel;
        w = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(5));
        pc = (pc_pool.size() != 0 && $urandom_range(3) != 0) ?
             pc_pool[$urandom_range(pc_pool.size() - 1)] : $urandom;
        sel = $urandom_range(99);
        if (sel < 28)
        begin
            pc = $urandom_range(32'hFFFF);
            pc_pool = {pc_pool, pc};
            if (pc_pool.size() > 16)
                void'(pc_pool.pop_front());
            send_op(wltt_pkg::KIND_PUSH, w, pc, pc + 32'($urandom_range(32'h3FFF)), $urandom,
                    3'($urandom), $urandom, $urandom);
        end
        else if (sel < 40)
            send_op(wltt_pkg::KIND_SEARCH, w, pc, $urandom, $urandom, 3'($urandom),
                    $urandom, $urandom);
        else if (sel < 48)
            send_op(wltt_pkg::KIND_SETBR, w, $urandom,
                    ($urandom_range(1) ? pc + 32'h800 : $urandom),
                    $urandom, 3'($urandom_range(7)), $urandom, $urandom);
        else if (sel < 55)
            send_op(wltt_pkg::KIND_POP, w, $urandom, $urandom, $urandom,
                    3'($urandom_range(7)), $urandom, $urandom);
        else if (sel < 63)
            send_op(wltt_pkg::KIND_ENDLOOP, w, $urandom, $urandom,
                    ($urandom_range(3) == 0 ? $urandom : pc + 32'($urandom_range(32'hFFF))),
                    3'd0, $urandom, $urandom);
        else if (sel < 88)
            send_op(wltt_pkg::KIND_UPDATE, w, $urandom, $urandom, $urandom,
                    3'($urandom_range(3)), $urandom, $urandom);
        else if (sel < 97)
            send_op(wltt_pkg::KIND_BIGGEST, w, $urandom, $urandom, $urandom, 3'($urandom),
                    $urandom, $urandom);
        else
            send_op(wltt_pkg::KIND_UNUSED, w, $urandom, $urandom, $urandom, 3'($urandom),
                    $urandom, $urandom);
    endtask

    task automatic test_random(input int n, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (n)
            random_op();
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (30)
                random_op();
        join
        drain();
    endtask

    initial
    begin
        error_count = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        kind = '0;
        warp = '0;
        target_pc = '0;
        branch_pc = '0;
        current_pc = '0;
        entry_index = '0;
        lane_mask = '0;
        cycle_stamp = '0;
        for (int i = 0; i < NWARP; i++)
            depth_of[i] = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(170, 36, 64);
        test_random(170, 64, 36);
        test_backpressure();
        test_random(170, 0, 0);
        repeat (100)
            @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire
